@@ design/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`else

`define DTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define DTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/dts_pkg.sv @@
// Types and constants shared by the deadline task scheduler modules.
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

    localparam int OP_BITS      = 2;
    localparam int ID_PORT_BITS = 8;
    localparam int DELAY_BITS   = 15;
    localparam int TICK_BITS    = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK     = 2'd0,
        OP_SCHEDULE = 2'd1,
        OP_ENQUEUE  = 2'd2,
        OP_PROCESS  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } state_t;

    // Strobes into the timer table.
    typedef struct packed {
        logic alloc;
        logic scan_rd;
    } tt_ctrl_t;

    // Strobes into the ready queue.
    typedef struct packed {
        logic push;
        logic pop;
    } rq_ctrl_t;

    // Ready queue status back to the sequencer.
    typedef struct packed {
        logic any;
        logic last;
    } rq_status_t;

endpackage

`default_nettype wire

@@ design/dts_timer_table.sv @@
// Timer table: slot memory of task id and deadline, valid bits, due check.
`timescale 1ns / 1ps
`default_nettype none

module dts_timer_table
    import dts_pkg::*;
#(
    parameter int SLOTS   = 8,
    parameter int ID_BITS = 8,
    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tt_ctrl_t             ctrl,
    input  logic [IW-1:0]        scan_idx,
    input  logic [ID_BITS-1:0]   alloc_id,
    input  logic [TICK_BITS-1:0] alloc_deadline,
    input  logic [TICK_BITS-1:0] tick_count,
    output logic                 due,
    output logic [ID_BITS-1:0]   due_id
);

    localparam int EW = ID_BITS + TICK_BITS;

    logic [EW-1:0]    slot_mem [SLOTS];
    logic [EW-1:0]    rd_data_reg;
    logic [IW-1:0]    chk_idx_reg;
    logic             chk_pend_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [IW-1:0]    free_idx;
    logic             free_any;

    // Lowest free slot.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_any = 1'b1;
                free_idx = IW'(k);
            end
        end
    end

    // The slot read last cycle is checked now; a due slot is freed.
    assign due    = chk_pend_reg && valid_reg[chk_idx_reg]
                    && (rd_data_reg[TICK_BITS-1:0] <= tick_count);
    assign due_id = rd_data_reg[EW-1:TICK_BITS];

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.alloc && free_any)
        begin
            valid_next[free_idx] = 1'b1;
        end
        if (due)
        begin
            valid_next[chk_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            chk_pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            chk_pend_reg <= ctrl.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.alloc && free_any)
        begin
            slot_mem[free_idx] <= {alloc_id, alloc_deadline};
        end
        if (ctrl.scan_rd)
        begin
            rd_data_reg <= slot_mem[scan_idx];
            chk_idx_reg <= scan_idx;
        end
    end

endmodule

`default_nettype wire

@@ design/dts_ready_queue.sv @@
// Ready queue: task id memory with valid bits, lowest-slot push and pop.
`timescale 1ns / 1ps
`default_nettype none

module dts_ready_queue
    import dts_pkg::*;
#(
    parameter int SLOTS   = 8,
    parameter int ID_BITS = 8,
    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rq_ctrl_t           ctrl,
    input  logic [ID_BITS-1:0] push_id,
    output rq_status_t         status,
    output logic [ID_BITS-1:0] rd_data
);

    logic [ID_BITS-1:0] ready_mem [SLOTS];
    logic [ID_BITS-1:0] rd_data_reg;
    logic               last_reg;
    logic               last_next;
    logic [SLOTS-1:0]   valid_reg;
    logic [SLOTS-1:0]   valid_next;
    logic [SLOTS-1:0]   others;
    logic [IW-1:0]      free_idx;
    logic               free_any;
    logic [IW-1:0]      head_idx;

    // Lowest free slot for a push and lowest occupied slot for a pop.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        head_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_any = 1'b1;
                free_idx = IW'(k);
            end
            else
            begin
                head_idx = IW'(k);
            end
        end
    end

    always_comb
    begin
        others           = valid_reg;
        others[head_idx] = 1'b0;
        last_next        = last_reg;
        valid_next       = valid_reg;
        if (ctrl.push && free_any)
        begin
            valid_next[free_idx] = 1'b1;
        end
        if (ctrl.pop)
        begin
            valid_next[head_idx] = 1'b0;
            last_next            = ~|others;
        end
    end

    assign status.any  = |valid_reg;
    assign status.last = last_reg;
    assign rd_data     = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && free_any)
        begin
            ready_mem[free_idx] <= push_id;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= ready_mem[head_idx];
        end
    end

endmodule

`default_nettype wire

@@ design/deadline_task_scheduler_unit.sv @@
// Top level of the deadline task scheduler: sequencer, tick counter, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The scheduler keeps a 32-bit millisecond counter, a timer table of
// SCHEDULE_SLOTS entries (task id and deadline) and a ready queue of
// QUEUE_SLOTS task ids, both held in synchronous memories with registered
// reads; occupancy lives in valid flip-flops that reset clears, so no
// clearing pass is needed. Each input word carries an op: a tick advances the
// counter, a schedule stores the task with deadline = counter + delay_ms in
// the lowest free timer slot (dropped when the table is full), an enqueue
// stores the task in the lowest free ready slot (dropped when the queue is
// full), and a process moves every due timer entry (deadline <= counter,
// plain unsigned compare, both sides wrapping) into the ready queue in slot
// order and then emits the queued ids in ready slot order as result words,
// marking the final one with last. A due task that finds the queue full is
// lost, but its timer slot is still freed. A process with an empty queue
// gives no result words. A process word starts a timer scan that reads one
// slot per cycle, with the due check on the slot read before it, then
// handles each emitted id as a ready memory read followed by a load of the
// result register, which result_stall can hold. The result register
// decouples the two sides: once the last id is loaded, a new input word is
// taken while it still waits.
module deadline_task_scheduler_unit
    import dts_pkg::*;
#(
    parameter int SCHEDULE_SLOTS = 8,
    parameter int QUEUE_SLOTS    = 8,
    parameter int TASK_ID_BITS   = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [OP_BITS-1:0]      op,
    input  logic [ID_PORT_BITS-1:0] task_id,
    input  logic [DELAY_BITS-1:0]   delay_ms,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [ID_PORT_BITS-1:0] run_task_id,
    output logic                    last
);

    localparam int SW = (SCHEDULE_SLOTS > 1) ? $clog2(SCHEDULE_SLOTS) : 1;
    localparam logic [SW:0] SCAN_END = SCHEDULE_SLOTS[SW:0];

    state_t                   state_reg;
    state_t                   state_next;
    logic [SW:0]              scan_cnt_reg;
    logic [SW:0]              scan_cnt_next;
    logic [TICK_BITS-1:0]     tick_count_reg;
    logic [TICK_BITS-1:0]     tick_count_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic [ID_PORT_BITS-1:0]  run_id_reg;
    logic [ID_PORT_BITS-1:0]  run_id_next;
    logic                     last_reg;
    logic                     last_next;

    tt_ctrl_t                 tt_ctrl;
    logic                     tt_due;
    logic [TASK_ID_BITS-1:0]  tt_due_id;
    rq_ctrl_t                 rq_ctrl;
    rq_status_t               rq_status;
    logic [TASK_ID_BITS-1:0]  rq_rd_data;
    logic [TASK_ID_BITS-1:0]  push_id;

    logic [TASK_ID_BITS+ID_PORT_BITS-1:0] id_in_ext;
    logic [TASK_ID_BITS-1:0]              id_in;
    logic [TASK_ID_BITS+ID_PORT_BITS-1:0] id_out_ext;
    logic [TICK_BITS-1:0]                 deadline;
    logic                                 out_free;

    // Keep the low TASK_ID_BITS of the incoming id; widen the stored id back
    // to the port width on the way out.
    assign id_in_ext  = {{TASK_ID_BITS{1'b0}}, task_id};
    assign id_in      = id_in_ext[TASK_ID_BITS-1:0];
    assign id_out_ext = {{ID_PORT_BITS{1'b0}}, rq_rd_data};
    assign deadline   = tick_count_reg + {{(TICK_BITS - DELAY_BITS){1'b0}}, delay_ms};

    // The result register can take a new word when empty or when its word
    // leaves at this edge.
    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != ST_IDLE);

    dts_timer_table #(
        .SLOTS   (SCHEDULE_SLOTS),
        .ID_BITS (TASK_ID_BITS)
    ) u_timer (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (tt_ctrl),
        .scan_idx       (scan_cnt_reg[SW-1:0]),
        .alloc_id       (id_in),
        .alloc_deadline (deadline),
        .tick_count     (tick_count_reg),
        .due            (tt_due),
        .due_id         (tt_due_id)
    );

    dts_ready_queue #(
        .SLOTS   (QUEUE_SLOTS),
        .ID_BITS (TASK_ID_BITS)
    ) u_ready (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rq_ctrl),
        .push_id (push_id),
        .status  (rq_status),
        .rd_data (rq_rd_data)
    );

    // Sequencer. The timer table is written only from idle and read only
    // during the scan, and the ready queue is pushed only from idle or the
    // scan and popped only while emitting, so no two accesses to the same
    // entry ever overlap and no forwarding is needed.
    always_comb
    begin
        state_next        = state_reg;
        scan_cnt_next     = scan_cnt_reg;
        tick_count_next   = tick_count_reg;
        result_valid_next = result_valid_reg;
        run_id_next       = run_id_reg;
        last_next         = last_reg;
        tt_ctrl           = '0;
        rq_ctrl           = '0;
        push_id           = tt_due_id;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (op_t'(op))
                        OP_TICK:
                        begin
                            tick_count_next = tick_count_reg + 1'b1;
                        end
                        OP_SCHEDULE:
                        begin
                            tt_ctrl.alloc = 1'b1;
                        end
                        OP_ENQUEUE:
                        begin
                            rq_ctrl.push = 1'b1;
                            push_id      = id_in;
                        end
                        OP_PROCESS:
                        begin
                            scan_cnt_next = '0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Read slot scan_cnt while checking the slot read before it.
                if (scan_cnt_reg < SCAN_END)
                begin
                    tt_ctrl.scan_rd = 1'b1;
                    scan_cnt_next   = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
                if (tt_due)
                begin
                    rq_ctrl.push = 1'b1;
                end
            end
            ST_EMIT_RD:
            begin
                if (rq_status.any)
                begin
                    rq_ctrl.pop = 1'b1;
                    state_next  = ST_EMIT_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    run_id_next       = id_out_ext[ID_PORT_BITS-1:0];
                    last_next         = rq_status.last;
                    state_next        = rq_status.last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_cnt_reg     <= '0;
            tick_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_cnt_reg     <= scan_cnt_next;
            tick_count_reg   <= tick_count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_id_reg <= run_id_next;
        last_reg   <= last_next;
    end

    assign result_valid = result_valid_reg;
    assign run_task_id  = run_id_reg;
    assign last         = last_reg;

    // A timer entry can only fall due while the scan is running.
    `DTS_ASSERT_IMPLY(a_due_in_scan, clk, rst_n, tt_due, state_reg == ST_SCAN)
    // A word that is not the last of its burst means more words are coming.
    `DTS_ASSERT_IMPLY(a_burst_open, clk, rst_n, result_valid && !last, state_reg != ST_IDLE)
    // A process always leaves the ready queue empty.
    `DTS_ASSERT_IMPLY(a_queue_drained, clk, rst_n, state_reg == ST_IDLE && $past(state_reg) == ST_EMIT_WAIT, !rq_status.any)
    // An accepted process word keeps the input side busy for the scan.
    `DTS_ASSERT_NEXT(a_process_busy, clk, rst_n, item_valid && !item_stall && op == OP_PROCESS, state_reg == ST_SCAN)

endmodule

`default_nettype wire
